>>> hw/rtl/vector_normalize_3d_defines.svh
// Assertion macros shared by the normalizer RTL.
`ifndef VECTOR_NORMALIZE_3D_DEFINES_SVH
`define VECTOR_NORMALIZE_3D_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VN3_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("vn3 assertion failed");

// Next-cycle implication, disabled during reset.
`define VN3_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("vn3 assertion failed");

`endif

>>> hw/rtl/vn3_pkg.sv
package vn3_pkg;

  localparam int CW       = 32;          // component width used
  localparam int FB       = 30;          // result fraction bits
  localparam int IN_W     = 32;          // input field width
  localparam int OUT_W    = 32;          // output field width
  localparam int SQW      = 2 * CW - 1;  // width of one square
  localparam int SW       = 2 * CW;      // width of the sum of squares
  localparam int QW       = 2 * FB + 1;  // quotient width
  localparam int RW       = FB + 1;      // root width
  localparam int LANE_LAT = QW + FB + 2; // lane register ranks
  localparam int FRONT    = 4;           // ranks ahead of the lanes
  localparam int SIDE_N   = FRONT + LANE_LAT;

  typedef struct packed {
    logic signed [IN_W-1:0] comp_x;
    logic signed [IN_W-1:0] comp_y;
    logic signed [IN_W-1:0] comp_z;
  } vn3_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] unit_x;
    logic signed [OUT_W-1:0] unit_y;
    logic signed [OUT_W-1:0] unit_z;
    logic                    zero_error;
  } vn3_out_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] neg;
    logic       zero;
  } vn3_side_t;

endpackage

>>> hw/rtl/vector_normalize_3d.sv
// Channel | Handshake             | Payload
// in      | in_valid / in_stall   | in_data  : comp_x, comp_y, comp_z (Q16.16)
// out     | out_valid / out_stall | out_data : unit_x, unit_y, unit_z (Q1.30), zero_error
//
// Takes one vector per cycle while out_stall does not hold the pipeline. The lane
// depth is set by one rank per quotient bit in each lane divider and one rank
// per root bit in each lane square root.
// Reset (rst, synchronous) clears only the valid chain and the output valid.
// The whole pipeline holds while a result waits under out_stall; in_stall
// follows that hold, so an item is taken whenever the output register drains.
module vector_normalize_3d (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  vn3_pkg::vn3_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vn3_pkg::vn3_out_t out_data
);
  import vn3_pkg::*;
  `include "vector_normalize_3d_defines.svh"

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Side band: valid, signs and zero flag travel alongside the lanes.
  vn3_side_t side [0:SIDE_N-1];
  vn3_side_t side_next;

  logic [CW-1:0]  raw  [0:2];
  logic [CW-1:0]  mag  [0:2];
  logic [CW-1:0]  absv [0:2];
  logic [SQW-1:0] sq2  [0:2];
  logic [SQW-1:0] sq3  [0:2];
  logic [SQW-1:0] sq4  [0:2];
  logic [SW-1:0]  sxy;
  logic [SW-1:0]  ssum;
  logic [RW-1:0]  root [0:2];

  assign raw[0] = in_data.comp_x[CW-1:0];
  assign raw[1] = in_data.comp_y[CW-1:0];
  assign raw[2] = in_data.comp_z[CW-1:0];

  // Rank 1: magnitude, sign and the zero test.
  always_comb begin
    side_next.valid = in_valid;
    for (int j = 0; j < 3; j++) begin
      side_next.neg[j] = raw[j][CW-1];
      absv[j]          = raw[j][CW-1] ? (~raw[j] + CW'(1)) : raw[j];
    end
    side_next.zero = (raw[0] == '0) && (raw[1] == '0) && (raw[2] == '0);
  end

  // Advance the side band; only the valid chain is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < SIDE_N; j++) begin
        side[j].valid <= 1'b0;
      end
    end else if (adv) begin
      side[0].valid <= side_next.valid;
      for (int j = 1; j < SIDE_N; j++) begin
        side[j].valid <= side[j-1].valid;
      end
    end
    if (adv) begin
      side[0].neg  <= side_next.neg;
      side[0].zero <= side_next.zero;
      for (int j = 1; j < SIDE_N; j++) begin
        side[j].neg  <= side[j-1].neg;
        side[j].zero <= side[j-1].zero;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        mag[j] <= absv[j];
        // Rank 2: squares.
        sq2[j] <= SQW'({{CW{1'b0}}, mag[j]} * {{CW{1'b0}}, mag[j]});
        // Ranks 3 and 4: carry squares beside the sum.
        sq3[j] <= sq2[j];
        sq4[j] <= sq3[j];
      end
      sxy  <= SW'(sq2[0]) + SW'(sq2[1]);
      ssum <= sxy + SW'(sq3[2]);
    end
  end

  // Three identical lanes: divide and take the root per component.
  genvar l;
  generate
    for (l = 0; l < 3; l++) begin : g_lane
      vn3_lane u_lane (
        .clk (clk),
        .en  (adv),
        .sq  (sq4[l]),
        .s   (ssum),
        .mag (root[l])
      );
    end
  endgenerate

  // Merge: apply signs, force zero for the zero vector, register the result.
  vn3_side_t last;
  logic signed [OUT_W-1:0] unit [0:2];
  assign last = side[SIDE_N-1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (last.zero) begin
        unit[j] = '0;
      end else if (last.neg[j]) begin
        unit[j] = -$signed(OUT_W'(root[j]));
      end else begin
        unit[j] = $signed(OUT_W'(root[j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.unit_x     <= unit[0];
      out_data.unit_y     <= unit[1];
      out_data.unit_z     <= unit[2];
      out_data.zero_error <= last.zero;
    end
  end

  `VN3_ASSERT_SAME(a_zero_clears, clk, rst, out_valid && out_data.zero_error,
    out_data.unit_x == '0 && out_data.unit_y == '0 && out_data.unit_z == '0)
  `VN3_ASSERT_SAME(a_hold_link, clk, rst, 1'b1, in_stall == (out_valid && out_stall))
  `VN3_ASSERT_NEXT(a_drain, clk, rst, !out_stall && !last.valid, !out_valid)

endmodule

>>> hw/rtl/vn3_div.sv
module vn3_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [vn3_pkg::SQW-1:0] sq,
  input  logic [vn3_pkg::SW-1:0]  s,
  output logic [vn3_pkg::QW-1:0]  quo_out
);
  import vn3_pkg::*;

  // Restoring division of sq * 2^(2*FB) by s, one quotient bit per rank.
  logic [SW-1:0] rem [0:QW];
  logic [SW-1:0] dvs [0:QW];
  logic [QW-1:0] quo [0:QW];
  logic          lsb;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= SW'(sq >> 1);
      dvs[0] <= s;
      quo[0] <= '0;
      lsb    <= sq[0];
    end
  end

  genvar i;
  generate
    for (i = 0; i < QW; i++) begin : g_step
      logic [SW:0] shifted;
      logic        ge;
      always_comb begin
        shifted = {rem[i], ((i == 0) ? lsb : 1'b0)};
        ge      = (shifted >= {1'b0, dvs[i]});
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= ge ? SW'(shifted - {1'b0, dvs[i]}) : shifted[SW-1:0];
          dvs[i+1] <= dvs[i];
          quo[i+1] <= {quo[i][QW-2:0], ge};
        end
      end
    end
  endgenerate

  assign quo_out = quo[QW];

endmodule

>>> hw/rtl/vn3_sqrt.sv
module vn3_sqrt (
  input  logic                   clk,
  input  logic                   en,
  input  logic [vn3_pkg::QW-1:0] rad,
  output logic [vn3_pkg::RW-1:0] root_out
);
  import vn3_pkg::*;

  localparam int PW = 2 * RW;

  // Digit-by-digit square root, two radicand bits per rank.
  logic [PW-1:0] radv [0:RW];
  logic [RW:0]   rem  [0:RW];
  logic [RW-1:0] root [0:RW];

  assign radv[0] = PW'(rad);
  assign rem[0]  = '0;
  assign root[0] = '0;

  genvar k;
  generate
    for (k = 0; k < RW; k++) begin : g_step
      logic [RW+2:0] shifted;
      logic [RW+2:0] trial;
      logic          ge;
      always_comb begin
        shifted = {rem[k], radv[k][2*(RW-1-k)+1 -: 2]};
        trial   = {1'b0, root[k], 2'b01};
        ge      = (shifted >= trial);
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1]  <= ge ? (RW+1)'(shifted - trial) : shifted[RW:0];
          root[k+1] <= {root[k][RW-2:0], ge};
          radv[k+1] <= radv[k];
        end
      end
    end
  endgenerate

  assign root_out = root[RW];

endmodule

>>> hw/rtl/vn3_lane.sv
module vn3_lane (
  input  logic                    clk,
  input  logic                    en,
  input  logic [vn3_pkg::SQW-1:0] sq,
  input  logic [vn3_pkg::SW-1:0]  s,
  output logic [vn3_pkg::RW-1:0]  mag
);
  import vn3_pkg::*;

  logic [QW-1:0] quo;

  vn3_div u_div (
    .clk     (clk),
    .en      (en),
    .sq      (sq),
    .s       (s),
    .quo_out (quo)
  );

  vn3_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .rad      (quo),
    .root_out (mag)
  );

endmodule
